// ===== hw/rtl/jsp_pkg.sv =====
// ----------------------------------------------------------------------------
// jsp_pkg
// Shared types and constants for the punctuator classifier: token kinds,
// character codes and the match result that travels between modules.
// ----------------------------------------------------------------------------
package jsp_pkg;

  localparam int CHAR_W = 8;
  localparam int AVAIL_W = 3;
  localparam int LEN_W = 3;
  localparam int KIND_W = 6;
  localparam int DEPTH_OUT_W = 16;
  localparam int WINDOW_CHARS = 4;

  // Token kinds, numbered densely in trie order.
  typedef enum logic [KIND_W-1:0] {
    KIND_INVALID = 6'd0,
    KIND_BANG, KIND_NE, KIND_NE_STRICT, KIND_PERCENT, KIND_MOD_ASSIGN,
    KIND_AMP, KIND_AND, KIND_AND_ASSIGN, KIND_LPAREN, KIND_RPAREN,
    KIND_STAR, KIND_MUL_ASSIGN, KIND_PLUS, KIND_INC, KIND_ADD_ASSIGN,
    KIND_COMMA, KIND_MINUS, KIND_DEC, KIND_SUB_ASSIGN, KIND_DOT,
    KIND_ELLIPSIS, KIND_SLASH, KIND_DIV_ASSIGN, KIND_COLON, KIND_SEMI,
    KIND_LT, KIND_SHL, KIND_SHL_ASSIGN, KIND_LE, KIND_ASSIGN,
    KIND_EQ, KIND_EQ_STRICT, KIND_ARROW, KIND_GT, KIND_GE,
    KIND_SHR, KIND_SHR_ASSIGN, KIND_USHR, KIND_USHR_ASSIGN, KIND_QUESTION,
    KIND_LBRACKET, KIND_RBRACKET, KIND_CARET, KIND_XOR_ASSIGN, KIND_LCURLY,
    KIND_PIPE, KIND_OR_ASSIGN, KIND_OR, KIND_RCURLY, KIND_TILDE
  } kind_t;

  localparam logic [CHAR_W-1:0] CH_BANG     = 8'h21;
  localparam logic [CHAR_W-1:0] CH_PERCENT  = 8'h25;
  localparam logic [CHAR_W-1:0] CH_AMP      = 8'h26;
  localparam logic [CHAR_W-1:0] CH_LPAREN   = 8'h28;
  localparam logic [CHAR_W-1:0] CH_RPAREN   = 8'h29;
  localparam logic [CHAR_W-1:0] CH_STAR     = 8'h2A;
  localparam logic [CHAR_W-1:0] CH_PLUS     = 8'h2B;
  localparam logic [CHAR_W-1:0] CH_COMMA    = 8'h2C;
  localparam logic [CHAR_W-1:0] CH_MINUS    = 8'h2D;
  localparam logic [CHAR_W-1:0] CH_DOT      = 8'h2E;
  localparam logic [CHAR_W-1:0] CH_SLASH    = 8'h2F;
  localparam logic [CHAR_W-1:0] CH_COLON    = 8'h3A;
  localparam logic [CHAR_W-1:0] CH_SEMI     = 8'h3B;
  localparam logic [CHAR_W-1:0] CH_LT       = 8'h3C;
  localparam logic [CHAR_W-1:0] CH_EQ       = 8'h3D;
  localparam logic [CHAR_W-1:0] CH_GT       = 8'h3E;
  localparam logic [CHAR_W-1:0] CH_QUEST    = 8'h3F;
  localparam logic [CHAR_W-1:0] CH_LBRACKET = 8'h5B;
  localparam logic [CHAR_W-1:0] CH_RBRACKET = 8'h5D;
  localparam logic [CHAR_W-1:0] CH_CARET    = 8'h5E;
  localparam logic [CHAR_W-1:0] CH_LCURLY   = 8'h7B;
  localparam logic [CHAR_W-1:0] CH_PIPE     = 8'h7C;
  localparam logic [CHAR_W-1:0] CH_RCURLY   = 8'h7D;
  localparam logic [CHAR_W-1:0] CH_TILDE    = 8'h7E;

  typedef struct packed {
    kind_t             kind;
    logic [LEN_W-1:0]  len;
  } match_t;

endpackage

// ===== hw/rtl/js_punctuator_longest_match_top.sv =====
// ----------------------------------------------------------------------------
// js_punctuator_longest_match_top
// Maximal-munch punctuator classifier with a curly-brace nesting counter.
// ----------------------------------------------------------------------------
// Usage:
//   The slave channel takes one lookahead window per request: four characters
//   and the count of valid leading characters. The master channel returns one
//   result per request: token kind, token length, unmatched-brace flag and
//   the nesting depth after the token.
//   A result is presented on the master side from the result register: the
//   input register captures the request, and the match and depth update sit
//   in front of the result register.
//   Throughput is one request per cycle while the receiver does not stall;
//   the match is a fixed-depth compare tree, the depth update combinational.
//   Reset clears both stage valids and sets the nesting depth to zero.
//   When the receiver stalls, the result holds, the input register fills,
//   and then s_tready drops until the master side moves again.
// ----------------------------------------------------------------------------
module js_punctuator_longest_match_top import jsp_pkg::*; #(
  parameter int NEST_WIDTH = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  // [7:0] first_char, [15:8] second_char, [23:16] third_char,
  // [31:24] fourth_char, [34:32] chars_available, [39:35] zero
  input  logic [39:0] s_tdata,
  output logic        m_tvalid,
  input  logic        m_tready,
  // [5:0] token_kind, [8:6] token_length, [9] brace_error,
  // [25:10] nesting_depth, [31:26] zero
  output logic [31:0] m_tdata
);

  logic                   in_valid;
  logic [CHAR_W-1:0]      in_c0;
  logic [CHAR_W-1:0]      in_c1;
  logic [CHAR_W-1:0]      in_c2;
  logic [CHAR_W-1:0]      in_c3;
  logic [AVAIL_W-1:0]     in_avail;

  logic                   out_valid;
  kind_t                  out_kind;
  logic [LEN_W-1:0]       out_len;
  logic                   out_err;
  logic [DEPTH_OUT_W-1:0] out_depth;

  logic                   out_free;
  logic                   advance;
  match_t                 match;
  logic [NEST_WIDTH-1:0]  depth_next;
  logic [31:0]            depth_wide;
  logic                   brace_error;

  assign out_free = !out_valid || m_tready;
  assign advance  = in_valid && out_free;
  assign s_tready = !in_valid || out_free;

  jsp_match u_match (
    .c0     (in_c0),
    .c1     (in_c1),
    .c2     (in_c2),
    .c3     (in_c3),
    .avail  (in_avail),
    .result (match)
  );

  jsp_depth #(
    .NEST_WIDTH (NEST_WIDTH)
  ) u_depth (
    .clk         (clk),
    .rst         (rst),
    .advance     (advance),
    .kind        (match.kind),
    .depth_next  (depth_next),
    .brace_error (brace_error)
  );

  assign depth_wide = 32'(depth_next);

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (s_tready) begin
        in_valid <= s_tvalid;
      end
      if (out_free) begin
        out_valid <= in_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      in_c0    <= s_tdata[7:0];
      in_c1    <= s_tdata[15:8];
      in_c2    <= s_tdata[23:16];
      in_c3    <= s_tdata[31:24];
      in_avail <= s_tdata[34:32];
    end
    if (advance) begin
      out_kind  <= match.kind;
      out_len   <= match.len;
      out_err   <= brace_error;
      out_depth <= depth_wide[DEPTH_OUT_W-1:0];
    end
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = {6'd0, out_depth, out_err, out_len, out_kind};

`ifndef SYNTHESIS
  a_err_only_on_close: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_err |-> out_kind == KIND_RCURLY && out_depth == '0)
    else $error("brace error on a result that is not an unmatched close");

  a_invalid_len_one: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_kind == KIND_INVALID |-> out_len == 3'd1)
    else $error("invalid token with length other than one");

  a_len_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> out_len != 3'd0 && out_len <= 3'd4)
    else $error("token length out of range");

  a_stall_holds_input: assert property (@(posedge clk) disable iff (rst)
    in_valid && !out_free |=> in_valid && $stable(in_c0) && $stable(in_avail))
    else $error("input register changed while the result was stalled");
`endif

endmodule

// ===== hw/rtl/jsp_match.sv =====
// ----------------------------------------------------------------------------
// jsp_match
// Longest-match punctuator classifier over a four-character window.
// ----------------------------------------------------------------------------
module jsp_match import jsp_pkg::*; (
  input  logic [CHAR_W-1:0]  c0,
  input  logic [CHAR_W-1:0]  c1,
  input  logic [CHAR_W-1:0]  c2,
  input  logic [CHAR_W-1:0]  c3,
  input  logic [AVAIL_W-1:0] avail,
  output match_t             result
);

  logic ok2;
  logic ok3;
  logic ok4;

  // A count of zero still takes the first character; counts above four are
  // limited to the window.
  assign ok2 = (avail >= 3'd2);
  assign ok3 = (avail >= 3'd3);
  assign ok4 = (avail >= 3'd4);

  always_comb begin
    result.kind = KIND_INVALID;
    result.len  = 3'd1;
    unique case (c0)
      CH_BANG: begin
        if (ok2 && c1 == CH_EQ) begin
          if (ok3 && c2 == CH_EQ) begin
            result.kind = KIND_NE_STRICT; result.len = 3'd3;
          end else begin
            result.kind = KIND_NE; result.len = 3'd2;
          end
        end else begin
          result.kind = KIND_BANG;
        end
      end
      CH_PERCENT: begin
        if (ok2 && c1 == CH_EQ) begin
          result.kind = KIND_MOD_ASSIGN; result.len = 3'd2;
        end else begin
          result.kind = KIND_PERCENT;
        end
      end
      CH_AMP: begin
        if (ok2 && c1 == CH_AMP) begin
          result.kind = KIND_AND; result.len = 3'd2;
        end else if (ok2 && c1 == CH_EQ) begin
          result.kind = KIND_AND_ASSIGN; result.len = 3'd2;
        end else begin
          result.kind = KIND_AMP;
        end
      end
      CH_LPAREN: result.kind = KIND_LPAREN;
      CH_RPAREN: result.kind = KIND_RPAREN;
      CH_STAR: begin
        if (ok2 && c1 == CH_EQ) begin
          result.kind = KIND_MUL_ASSIGN; result.len = 3'd2;
        end else begin
          result.kind = KIND_STAR;
        end
      end
      CH_PLUS: begin
        if (ok2 && c1 == CH_PLUS) begin
          result.kind = KIND_INC; result.len = 3'd2;
        end else if (ok2 && c1 == CH_EQ) begin
          result.kind = KIND_ADD_ASSIGN; result.len = 3'd2;
        end else begin
          result.kind = KIND_PLUS;
        end
      end
      CH_COMMA: result.kind = KIND_COMMA;
      CH_MINUS: begin
        if (ok2 && c1 == CH_MINUS) begin
          result.kind = KIND_DEC; result.len = 3'd2;
        end else if (ok2 && c1 == CH_EQ) begin
          result.kind = KIND_SUB_ASSIGN; result.len = 3'd2;
        end else begin
          result.kind = KIND_MINUS;
        end
      end
      CH_DOT: begin
        // Two dots alone are not a token, so they fall back to a single dot.
        if (ok3 && c1 == CH_DOT && c2 == CH_DOT) begin
          result.kind = KIND_ELLIPSIS; result.len = 3'd3;
        end else begin
          result.kind = KIND_DOT;
        end
      end
      CH_SLASH: begin
        if (ok2 && c1 == CH_EQ) begin
          result.kind = KIND_DIV_ASSIGN; result.len = 3'd2;
        end else begin
          result.kind = KIND_SLASH;
        end
      end
      CH_COLON: result.kind = KIND_COLON;
      CH_SEMI:  result.kind = KIND_SEMI;
      CH_LT: begin
        if (ok2 && c1 == CH_LT) begin
          if (ok3 && c2 == CH_EQ) begin
            result.kind = KIND_SHL_ASSIGN; result.len = 3'd3;
          end else begin
            result.kind = KIND_SHL; result.len = 3'd2;
          end
        end else if (ok2 && c1 == CH_EQ) begin
          result.kind = KIND_LE; result.len = 3'd2;
        end else begin
          result.kind = KIND_LT;
        end
      end
      CH_EQ: begin
        if (ok2 && c1 == CH_EQ) begin
          if (ok3 && c2 == CH_EQ) begin
            result.kind = KIND_EQ_STRICT; result.len = 3'd3;
          end else begin
            result.kind = KIND_EQ; result.len = 3'd2;
          end
        end else if (ok2 && c1 == CH_GT) begin
          result.kind = KIND_ARROW; result.len = 3'd2;
        end else begin
          result.kind = KIND_ASSIGN;
        end
      end
      CH_GT: begin
        if (ok2 && c1 == CH_GT) begin
          if (ok3 && c2 == CH_GT) begin
            if (ok4 && c3 == CH_EQ) begin
              result.kind = KIND_USHR_ASSIGN; result.len = 3'd4;
            end else begin
              result.kind = KIND_USHR; result.len = 3'd3;
            end
          end else if (ok3 && c2 == CH_EQ) begin
            result.kind = KIND_SHR_ASSIGN; result.len = 3'd3;
          end else begin
            result.kind = KIND_SHR; result.len = 3'd2;
          end
        end else if (ok2 && c1 == CH_EQ) begin
          result.kind = KIND_GE; result.len = 3'd2;
        end else begin
          result.kind = KIND_GT;
        end
      end
      CH_QUEST:    result.kind = KIND_QUESTION;
      CH_LBRACKET: result.kind = KIND_LBRACKET;
      CH_RBRACKET: result.kind = KIND_RBRACKET;
      CH_CARET: begin
        if (ok2 && c1 == CH_EQ) begin
          result.kind = KIND_XOR_ASSIGN; result.len = 3'd2;
        end else begin
          result.kind = KIND_CARET;
        end
      end
      CH_LCURLY: result.kind = KIND_LCURLY;
      CH_PIPE: begin
        if (ok2 && c1 == CH_EQ) begin
          result.kind = KIND_OR_ASSIGN; result.len = 3'd2;
        end else if (ok2 && c1 == CH_PIPE) begin
          result.kind = KIND_OR; result.len = 3'd2;
        end else begin
          result.kind = KIND_PIPE;
        end
      end
      CH_RCURLY: result.kind = KIND_RCURLY;
      CH_TILDE:  result.kind = KIND_TILDE;
      default: begin
        result.kind = KIND_INVALID;
        result.len  = 3'd1;
      end
    endcase
  end

endmodule

// ===== hw/rtl/jsp_depth.sv =====
// ----------------------------------------------------------------------------
// jsp_depth
// Curly-brace nesting counter: saturates at its top, flags an unmatched close.
// ----------------------------------------------------------------------------
module jsp_depth import jsp_pkg::*; #(
  parameter int NEST_WIDTH = 16
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  advance,
  input  kind_t                 kind,
  output logic [NEST_WIDTH-1:0] depth_next,
  output logic                  brace_error
);

  logic [NEST_WIDTH-1:0] brace_depth;
  logic                  at_top;
  logic                  at_zero;

  assign at_top  = (brace_depth == {NEST_WIDTH{1'b1}});
  assign at_zero = (brace_depth == '0);

  always_comb begin
    depth_next  = brace_depth;
    brace_error = 1'b0;
    if (kind == KIND_LCURLY) begin
      if (!at_top) begin
        depth_next = brace_depth + 1'b1;
      end
    end else if (kind == KIND_RCURLY) begin
      if (at_zero) begin
        brace_error = 1'b1;
      end else begin
        depth_next = brace_depth - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      brace_depth <= '0;
    end else if (advance) begin
      brace_depth <= depth_next;
    end
  end

endmodule
